// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while out of reset
`define DSV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define DSV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/dsv_pkg.sv =====
// Types, constants and helper functions of the date string validator
package dsv_pkg;

    localparam int CHAR_W    = 8;
    localparam int DIG_W     = 7;
    localparam int POS_W     = 4;
    localparam int YEAR_W    = 14;
    localparam int DATE_W    = 27;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 32;

    localparam logic [POS_W-1:0] TEXT_LEN   = 4'd10;
    localparam logic [POS_W-1:0] LAST_POS   = 4'd9;
    localparam logic [POS_W-1:0] POS_SAT    = 4'd11;
    localparam logic [POS_W-1:0] SEP_POS_A  = 4'd4;
    localparam logic [POS_W-1:0] SEP_POS_B  = 4'd7;
    localparam logic [POS_W-1:0] YLOW_START = 4'd2;
    localparam logic [POS_W-1:0] MON_START  = 4'd5;
    localparam logic [POS_W-1:0] DAY_START  = 4'd8;

    localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

    localparam logic [DATE_W-1:0] FALLBACK_DATE = 27'd20010101;
    localparam logic [DATE_W-1:0] MAX_DATE_RST  = 27'd99991231;
    localparam logic [YEAR_W-1:0] MIN_YEAR_RST  = 14'd1900;
    localparam logic [DIG_W-1:0]  MONTHS        = 7'd12;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_LEN,
        ST_BAD_CHAR,
        ST_BAD_CAL,
        ST_AFTER_MAX
    } t_status;

    // Fields collected from one complete text
    typedef struct packed {
        logic [DIG_W-1:0] cent;
        logic [DIG_W-1:0] ylow;
        logic [DIG_W-1:0] month;
        logic [DIG_W-1:0] day;
        logic             len_ok;
        logic             fmt_bad;
    } t_tok;

    typedef struct packed {
        logic [YEAR_W-1:0] min_year;
        logic [DATE_W-1:0] max_date;
        logic              confirm;
    } t_cfg;

    function automatic logic [DIG_W-1:0] push_digit(input logic [DIG_W-1:0] acc,
                                                    input logic [3:0] d);
        logic [10:0] t;
        t = {4'b0, acc} * 11'd10 + {7'b0, d};
        return t[DIG_W-1:0];
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/dsv_parse.sv =====
// Character front end: position tracking, format check and digit accumulation
module dsv_parse (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic                      i_ready,
    input  logic [dsv_pkg::CHAR_W-1:0] i_char,
    input  logic                      i_last,
    output logic                      o_tok_vld,
    output dsv_pkg::t_tok             o_tok
);
    import dsv_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [DIG_W-1:0] r_cent, r_ylow, r_mon, r_day;
    logic [DIG_W-1:0] u_cent, u_ylow, u_mon, u_day;
    logic [DIG_W-1:0] n_cent, n_ylow, n_mon, n_day;
    logic             r_bad, u_bad, n_bad;
    logic             acc, is_sep, is_dig, sep_ok;
    logic [3:0]       d;
    logic [CHAR_W-1:0] diff;

    assign acc    = i_vld & i_ready;
    assign is_sep = (r_pos == SEP_POS_A) || (r_pos == SEP_POS_B);
    assign is_dig = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign sep_ok = (i_char == CH_DASH) || (i_char == CH_DOT);
    assign diff   = i_char - CH_ZERO;
    assign d      = diff[3:0];

    always_comb begin
        u_cent = r_cent;
        u_ylow = r_ylow;
        u_mon  = r_mon;
        u_day  = r_day;
        u_bad  = r_bad;
        if (r_pos < TEXT_LEN) begin
            if (is_sep) begin
                if (!sep_ok) u_bad = 1'b1;
            end else if (!is_dig) begin
                u_bad = 1'b1;
            end else if (r_pos < YLOW_START) begin
                u_cent = push_digit(r_cent, d);
            end else if (r_pos < SEP_POS_A) begin
                u_ylow = push_digit(r_ylow, d);
            end else if (r_pos < DAY_START) begin
                u_mon = push_digit(r_mon, d);
            end else begin
                u_day = push_digit(r_day, d);
            end
        end
    end

    always_comb begin
        n_pos  = r_pos;
        n_cent = r_cent;
        n_ylow = r_ylow;
        n_mon  = r_mon;
        n_day  = r_day;
        n_bad  = r_bad;
        if (acc) begin
            if (i_last) begin
                n_pos  = '0;
                n_cent = '0;
                n_ylow = '0;
                n_mon  = '0;
                n_day  = '0;
                n_bad  = 1'b0;
            end else begin
                n_pos  = (r_pos < POS_SAT) ? r_pos + 4'd1 : r_pos;
                n_cent = u_cent;
                n_ylow = u_ylow;
                n_mon  = u_mon;
                n_day  = u_day;
                n_bad  = u_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_cent <= '0;
            r_ylow <= '0;
            r_mon  <= '0;
            r_day  <= '0;
            r_bad  <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_cent <= n_cent;
            r_ylow <= n_ylow;
            r_mon  <= n_mon;
            r_day  <= n_day;
            r_bad  <= n_bad;
        end
    end

    assign o_tok_vld     = acc & i_last;
    assign o_tok.cent    = u_cent;
    assign o_tok.ylow    = u_ylow;
    assign o_tok.month   = u_mon;
    assign o_tok.day     = u_day;
    assign o_tok.len_ok  = (r_pos == LAST_POS);
    assign o_tok.fmt_bad = u_bad;

endmodule

// ===== hdl/dsv_check.sv =====
// Calendar check pipeline: year build, month length, packing, max-date compare
module dsv_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tok_vld,
    input  dsv_pkg::t_tok               i_tok,
    input  dsv_pkg::t_cfg               i_cfg,
    output logic                        o_ready,
    output logic                        o_vld,
    input  logic                        i_out_ready,
    output logic [dsv_pkg::TDATA_W-1:0] o_tdata
);
    import dsv_pkg::*;

    // stage B: captured text fields
    logic r_b_vld;
    t_tok r_b;
    // stage C: year and month/day sums
    logic              r_c_vld, r_c_leap;
    logic [YEAR_W-1:0] r_c_year, r_c_md;
    logic [DIG_W-1:0]  r_c_mon, r_c_day;
    t_status           r_c_pre;
    // stage D: calendar result
    logic              r_d_vld;
    logic [DATE_W-1:0] r_d_packed;
    t_status           r_d_status;
    // stage E: output word
    logic              r_e_vld;
    logic [DATE_W-1:0] r_e_packed;
    t_status           r_e_status;

    logic b_ready, c_ready, d_ready, e_ready;
    logic              n_c_leap, cal_ok;
    logic [YEAR_W-1:0] n_c_year, n_c_md;
    logic [DATE_W-1:0] n_d_packed;
    t_status           n_c_pre, n_d_status, n_e_status;

    assign e_ready = !r_e_vld || i_out_ready;
    assign d_ready = !r_d_vld || e_ready;
    assign c_ready = !r_c_vld || d_ready;
    assign b_ready = !r_b_vld || c_ready;

    always_comb begin
        n_c_year = {7'b0, r_b.cent} * 14'd100 + {7'b0, r_b.ylow};
        n_c_md   = {7'b0, r_b.month} * 14'd100 + {7'b0, r_b.day};
        // year mod 4 follows the low pair; century years need the century pair
        n_c_leap = ((r_b.ylow[1:0] == 2'd0) && (r_b.ylow != '0))
                || ((r_b.ylow == '0) && (r_b.cent[1:0] == 2'd0));
        if (!r_b.len_ok)      n_c_pre = ST_BAD_LEN;
        else if (r_b.fmt_bad) n_c_pre = ST_BAD_CHAR;
        else                  n_c_pre = ST_OK;
    end

    always_comb begin
        cal_ok = (r_c_year >= i_cfg.min_year) && (r_c_mon != '0) && (r_c_mon <= MONTHS)
              && (r_c_day != '0)
              && (r_c_day <= {2'b0, month_len(r_c_mon[3:0], r_c_leap)});
        n_d_packed = FALLBACK_DATE;
        if (r_c_pre != ST_OK) begin
            n_d_status = r_c_pre;
        end else if (!cal_ok) begin
            n_d_status = ST_BAD_CAL;
        end else begin
            n_d_status = ST_OK;
            n_d_packed = {13'b0, r_c_year} * 27'd10000 + {13'b0, r_c_md};
        end
    end

    always_comb begin
        if ((r_d_status == ST_OK) && i_cfg.confirm && (r_d_packed > i_cfg.max_date))
            n_e_status = ST_AFTER_MAX;
        else
            n_e_status = r_d_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else begin
            if (b_ready) r_b_vld <= i_tok_vld;
            if (c_ready) r_c_vld <= r_b_vld;
            if (d_ready) r_d_vld <= r_c_vld;
            if (e_ready) r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && i_tok_vld) r_b <= i_tok;
        if (c_ready && r_b_vld) begin
            r_c_year <= n_c_year;
            r_c_md   <= n_c_md;
            r_c_mon  <= r_b.month;
            r_c_day  <= r_b.day;
            r_c_leap <= n_c_leap;
            r_c_pre  <= n_c_pre;
        end
        if (d_ready && r_c_vld) begin
            r_d_packed <= n_d_packed;
            r_d_status <= n_d_status;
        end
        if (e_ready && r_d_vld) begin
            r_e_packed <= r_d_packed;
            r_e_status <= n_e_status;
        end
    end

    assign o_ready = b_ready;
    assign o_vld   = r_e_vld;
    assign o_tdata = {1'b0, r_e_status, (r_e_status == ST_OK), r_e_packed};

endmodule

// ===== hdl/date_string_validator_unit.sv =====
// Top level of the date string validator: configuration registers and stage wiring
//
// Input stream (s_axis): one ASCII character per word, tlast on the final
// character of each date text. Every character is checked and folded into the
// running state when taken, so a word can be accepted on any cycle with tready high.
// Output stream (m_axis): one word per text, issued for the tlast character,
// carrying the packed YYYYMMDD date, the accepted flag and a status code
// (ok, bad length, bad character, bad calendar, after max date).
// Path of a result: the fields of the tlast character are registered in stage B
// (capture), then C (year build), D (calendar check) and E (max-date compare).
// Throughput: one character per cycle while s_axis_tready is high, set by the
// character front end; the check pipeline holds up to four results in flight.
// Receiver stall: results wait in the pipeline registers; s_axis_tready stays
// high while any stage can still take a word, and drops once all are full.
// Reset (synchronous, active low): clears the text state and the pipeline,
// and loads min year 1900, max date 99991231, confirm mode off.
// The user must write configuration through i_cfg_we/i_cfg_index/i_cfg_wdata only
// while no text is in progress and no result is pending; the block does not enforce it.
module date_string_validator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dsv_pkg::CHAR_W-1:0]    s_axis_tdata,   // [7:0] character
    input  logic                          s_axis_tlast,   // last character of text
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dsv_pkg::TDATA_W-1:0]   m_axis_tdata,   // [26:0] packed_date,
                                                          // [27] accepted,
                                                          // [30:28] status, [31] zero
    input  logic                          i_cfg_we,
    input  logic [dsv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dsv_pkg::DATE_W-1:0]    i_cfg_wdata
);
    import dsv_pkg::*;

    logic [YEAR_W-1:0] r_min_year;
    logic [DATE_W-1:0] r_max_date;
    logic              r_confirm;
    t_cfg              cfg;
    t_tok              tok;
    logic              tok_vld, ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RST;
            r_max_date <= MAX_DATE_RST;
            r_confirm  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_YEAR: r_min_year <= i_cfg_wdata[YEAR_W-1:0];
                CFG_MAX_DATE: r_max_date <= i_cfg_wdata;
                CFG_CONFIRM:  r_confirm  <= i_cfg_wdata[0];
                default: ;    // unused index, write dropped
            endcase
        end
    end

    assign cfg.min_year = r_min_year;
    assign cfg.max_date = r_max_date;
    assign cfg.confirm  = r_confirm;

    // per-character front end
    dsv_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (s_axis_tvalid),
        .i_ready   (ready),
        .i_char    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .o_tok_vld (tok_vld),
        .o_tok     (tok)
    );

    // per-text calendar pipeline and output register
    dsv_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_vld   (tok_vld),
        .i_tok       (tok),
        .i_cfg       (cfg),
        .o_ready     (ready),
        .o_vld       (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

    assign s_axis_tready = ready;

endmodule

// ===== hdl/dsv_checker.sv =====
// Port-level checker for the date string validator, bound to the top level
`include "assert_macros.svh"

module dsv_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [dsv_pkg::CHAR_W-1:0]    s_axis_tdata,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [dsv_pkg::TDATA_W-1:0]   m_axis_tdata,
    input logic                          i_cfg_we,
    input logic [dsv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [dsv_pkg::DATE_W-1:0]    i_cfg_wdata
);
    import dsv_pkg::*;

    logic            out_fail;
    logic [2:0]      st;

    assign st       = m_axis_tdata[30:28];
    assign out_fail = (st != ST_OK) && (st != ST_AFTER_MAX);

    // stalled result word must hold
    `DSV_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

    // accepted flag agrees with the status code
    `DSV_ASSERT(a_acc_status, m_axis_tvalid |-> (m_axis_tdata[27] == (st == ST_OK)), "accepted flag disagrees with status")

    // failed texts carry the fallback date
    `DSV_ASSERT(a_fail_date, m_axis_tvalid && out_fail |-> (m_axis_tdata[26:0] == FALLBACK_DATE), "failed text without fallback date")

    // no result word straight after reset
    `DSV_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    // input is only held off while a result word waits on a stalled receiver
    `DSV_ASSERT(a_full_stall, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without a blocked result")

    logic unused_ports;
    assign unused_ports = i_cfg_we ^ (^i_cfg_index) ^ (^i_cfg_wdata)
                        ^ s_axis_tvalid ^ s_axis_tlast ^ (^s_axis_tdata);

endmodule

bind date_string_validator_unit dsv_checker u_dsv_checker (.*);
